[sv/jcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared types and constants for the joystick calibrate-and-scale block.
// ----------------------------------------------------------------------------
package jcs_pkg;

  localparam int PERCENT_FULL = 100;
  localparam int PCT_W        = 8;
  localparam int DZ_W         = 6;
  localparam logic [DZ_W-1:0] DEADZONE_RESET = 6'd5;

  typedef enum logic [1:0] {
    CMD_CAL  = 2'd0,
    CMD_CAP  = 2'd1,
    CMD_CONV = 2'd2
  } cmd_t;

  // request from the top level to one axis lane
  typedef struct packed {
    logic start;
    cmd_t cmd;
  } lane_req_t;

  // lane status back to the merge stage
  typedef struct packed {
    logic             valid;
    logic [PCT_W-1:0] percent;
  } lane_stat_t;

endpackage

[sv/jcs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jcs_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  // divisor held from start, the operand inputs may move while busy
  assign rem_sh = {rem_r, q_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[sv/jcs_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_lane
// One axis: max/idle tracking, deadzone check and percent scaling.
// ----------------------------------------------------------------------------
module jcs_lane #(
  parameter int ADC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jcs_pkg::lane_req_t    req,
  input  logic [ADC_BITS-1:0]   raw,
  input  logic [jcs_pkg::DZ_W-1:0] deadzone,
  input  logic                  ack,
  output jcs_pkg::lane_stat_t   stat
);
  import jcs_pkg::*;

  localparam int NUM_W = ADC_BITS + 7;

  typedef enum logic [1:0] {L_IDLE, L_DIV, L_DONE} lstate_t;

  lstate_t             state_r, state_nxt;
  logic [ADC_BITS-1:0] max_r, max_nxt;
  logic [ADC_BITS-1:0] idle_r, idle_nxt;
  logic                neg_r, neg_nxt;
  logic [PCT_W-1:0]    pct_r, pct_nxt;
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [ADC_BITS-1:0] div_den;
  logic                div_done;
  logic [NUM_W-1:0]    div_quot;
  logic [ADC_BITS-1:0] delta;
  logic                below;

  assign below = (raw <= idle_r);
  assign delta = below ? (idle_r - raw) : (raw - idle_r);

  always_comb begin
    state_nxt = state_r;
    max_nxt   = max_r;
    idle_nxt  = idle_r;
    neg_nxt   = neg_r;
    pct_nxt   = pct_r;
    div_start = 1'b0;
    div_num   = below ? NUM_W'(raw) * NUM_W'(PERCENT_FULL)
                      : NUM_W'(raw - idle_r) * NUM_W'(PERCENT_FULL);
    div_den   = below ? idle_r : (max_r - idle_r);
    case (state_r)
      L_IDLE: begin
        if (req.start) begin
          pct_nxt   = '0;
          state_nxt = L_DONE;
          case (req.cmd)
            CMD_CAL: begin
              if (raw > max_r) max_nxt = raw;
            end
            CMD_CAP: begin
              idle_nxt = raw;
            end
            CMD_CONV: begin
              if (delta <= ADC_BITS'(deadzone)) begin
                pct_nxt = '0;
              end else if (!below && max_r <= idle_r) begin
                pct_nxt = PCT_W'(PERCENT_FULL);
              end else begin
                // idle is nonzero when below here: delta > deadzone >= 0
                neg_nxt   = below;
                div_start = 1'b1;
                state_nxt = L_DIV;
              end
            end
            default: begin
              pct_nxt = '0;
            end
          endcase
        end
      end
      L_DIV: begin
        if (div_done) begin
          if (neg_r) begin
            pct_nxt = {1'b0, div_quot[PCT_W-2:0]} - PCT_W'(PERCENT_FULL);
          end else if (div_quot > NUM_W'(PERCENT_FULL)) begin
            pct_nxt = PCT_W'(PERCENT_FULL);
          end else begin
            pct_nxt = {1'b0, div_quot[PCT_W-2:0]};
          end
          state_nxt = L_DONE;
        end
      end
      L_DONE: begin
        if (ack) state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      max_r   <= '0;
      idle_r  <= '0;
    end else begin
      state_r <= state_nxt;
      max_r   <= max_nxt;
      idle_r  <= idle_nxt;
    end
    neg_r <= neg_nxt;
    pct_r <= pct_nxt;
  end

  jcs_div #(
    .NUM_W (NUM_W),
    .DEN_W (ADC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign stat.valid   = (state_r == L_DONE);
  assign stat.percent = pct_r;

endmodule

[sv/joystick_calibrate_and_scale_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_calibrate_and_scale_top
// Two-axis joystick conditioner: calibration, idle capture, percent output.
// ----------------------------------------------------------------------------
// One request at a time. Calibrate and capture requests reach the output
// register through the lane's done state with zero in both fields. A convert
// request runs a setup step, then one iteration per quotient bit (ADC_BITS+7
// bits) of the bit-serial divider in each axis lane, then a step to scale
// and one to merge into the output register. Samples inside the deadzone,
// or above idle with no usable maximum, skip the divider and finish as
// fast as a calibrate request. The next request is accepted as soon as a
// result has moved to the output register, even if that result is still
// stalled downstream.
module joystick_calibrate_and_scale_top #(
  parameter int ADC_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration: deadzone register
  input  logic                     cfg_we,
  input  logic [jcs_pkg::DZ_W-1:0] cfg_wdata,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [ADC_BITS-1:0]      in_raw_x,
  input  logic [ADC_BITS-1:0]      in_raw_y,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [7:0]        out_x_percent,
  output logic signed [7:0]        out_y_percent
);
  import jcs_pkg::*;

  logic             pending_r, pending_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0] out_x_r, out_x_nxt;
  logic [PCT_W-1:0] out_y_r, out_y_nxt;
  logic [DZ_W-1:0]  deadzone_r;
  logic             accept;
  logic             take;
  lane_req_t        req;
  lane_stat_t       stat_x, stat_y;

  assign accept = in_valid && !pending_r;
  assign in_stall = pending_r;

  assign req.start = accept;
  assign req.cmd   = cmd_t'(in_cmd);

  // merge: both lanes finished and output register free
  assign take = stat_x.valid && stat_y.valid && (!out_valid_r || !out_stall);

  always_comb begin
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = stat_x.percent;
      out_y_nxt     = stat_y.percent;
      pending_nxt   = 1'b0;
    end
    if (accept) pending_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      deadzone_r  <= DEADZONE_RESET;
    end else begin
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) deadzone_r <= cfg_wdata;
    end
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

  jcs_lane #(
    .ADC_BITS (ADC_BITS)
  ) u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .raw      (in_raw_x),
    .deadzone (deadzone_r),
    .ack      (take),
    .stat     (stat_x)
  );

  jcs_lane #(
    .ADC_BITS (ADC_BITS)
  ) u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .raw      (in_raw_y),
    .deadzone (deadzone_r),
    .ack      (take),
    .stat     (stat_y)
  );

  assign out_valid     = out_valid_r;
  assign out_x_percent = $signed(out_x_r);
  assign out_y_percent = $signed(out_y_r);

endmodule
